[rtl/mgi_pkg.sv]
// ----------------------------------------------------------------------------
// mgi_pkg
// Shared types and constants of the multilinear grid interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package mgi_pkg;

  localparam int unsigned Dims         = 4;
  localparam int unsigned PointsPerDim = 8;
  localparam int unsigned NumFields    = 4;
  localparam int unsigned TablePoints  = 4096;
  localparam int unsigned TableSlots   = 4;
  localparam int unsigned TableDepth   = TablePoints * TableSlots;
  localparam int unsigned AddrW        = $clog2(TableDepth);
  localparam int unsigned PointW       = $clog2(TablePoints);
  localparam int unsigned DimW         = (Dims > 1) ? $clog2(Dims) : 1;
  localparam int unsigned CornerW      = Dims;
  localparam int unsigned FieldW       = 2;
  localparam int unsigned CellW        = $clog2(PointsPerDim);
  localparam int unsigned CfgIdxW      = 3;
  localparam int unsigned AccW         = 56;

  typedef enum logic [CfgIdxW-1:0] {
    CfgMin0 = 3'd0, CfgMin1 = 3'd1, CfgMin2 = 3'd2, CfgMin3 = 3'd3,
    CfgInv0 = 3'd4, CfgInv1 = 3'd5, CfgInv2 = 3'd6, CfgInv3 = 3'd7
  } cfg_idx_e;

  typedef enum logic {
    OpLoad = 1'b0,
    OpEval = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    StIdle, StMap, StCorner, StDrain, StEmit
  } state_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic             load_wr;
    logic             capture;
    logic             map_en;
    logic [DimW-1:0]  map_dim;
    logic             weight_en;
    logic [DimW-1:0]  weight_dim;
    logic             corner_rd;
    logic [CornerW-1:0] corner;
    logic             acc_clear;
    logic             acc_en;
    logic             emit;
    logic [FieldW-1:0] emit_field;
  } ctrl_t;

endpackage

`default_nettype wire

[rtl/mgi_ctrl.sv]
// ----------------------------------------------------------------------------
// mgi_ctrl
// Sequencer: maps the coordinates, walks corners and field slots, then drains and emits the fields.
// ----------------------------------------------------------------------------
`default_nettype none

module mgi_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  input  wire logic          op_i,
  output logic               busy,
  output mgi_pkg::ctrl_t     ctrl_o
);

  // Per corner: Dims weight steps, then NumFields reads and accumulates.
  localparam int unsigned StepW = 4;

  mgi_pkg::state_e state_q, state_d;
  logic [StepW-1:0] step_q, step_d;
  logic [mgi_pkg::CornerW-1:0] corner_q, corner_d;
  logic [mgi_pkg::DimW-1:0] dim_q, dim_d;
  logic [2:0] drain_q, drain_d;
  logic acc_v_q;
  logic [mgi_pkg::FieldW-1:0] acc_f_q;
  logic [mgi_pkg::FieldW-1:0] field_q, field_d;

  localparam logic [StepW-1:0] LastWStep = StepW'(mgi_pkg::Dims - 1);
  localparam logic [StepW-1:0] LastStep  = StepW'(mgi_pkg::Dims + mgi_pkg::NumFields - 1);

  always_comb begin
    state_d  = state_q;
    step_d   = step_q;
    corner_d = corner_q;
    dim_d    = dim_q;
    drain_d  = drain_q;
    field_d  = field_q;
    unique case (state_q)
      mgi_pkg::StIdle: begin
        if (start && op_i == mgi_pkg::OpEval) begin
          state_d = mgi_pkg::StMap;
          dim_d   = '0;
        end
      end
      mgi_pkg::StMap: begin
        if (dim_q == mgi_pkg::DimW'(mgi_pkg::Dims - 1)) begin
          state_d  = mgi_pkg::StCorner;
          step_d   = '0;
          corner_d = '0;
        end else begin
          dim_d = dim_q + 1'b1;
        end
      end
      mgi_pkg::StCorner: begin
        if (step_q == LastStep) begin
          step_d = '0;
          if (corner_q == '1) begin
            state_d = mgi_pkg::StDrain;
            drain_d = '0;
          end else begin
            corner_d = corner_q + 1'b1;
          end
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      mgi_pkg::StDrain: begin
        drain_d = drain_q + 1'b1;
        if (drain_q == 3'd2) begin
          state_d = mgi_pkg::StEmit;
          field_d = '0;
        end
      end
      mgi_pkg::StEmit: begin
        field_d = field_q + 1'b1;
        if (field_q == mgi_pkg::FieldW'(mgi_pkg::NumFields - 1)) begin
          state_d = mgi_pkg::StIdle;
        end
      end
      default: state_d = mgi_pkg::StIdle;
    endcase
  end

  always_comb begin
    ctrl_o            = '0;
    ctrl_o.corner     = corner_q;
    ctrl_o.map_dim    = dim_q;
    ctrl_o.weight_dim = step_q[mgi_pkg::DimW-1:0];
    ctrl_o.emit_field = field_q;
    ctrl_o.acc_en     = acc_v_q;
    // The accumulated field is the one read earlier, held in acc_f_q.
    ctrl_o.emit_field = (state_q == mgi_pkg::StEmit) ? field_q : acc_f_q;
    unique case (state_q)
      mgi_pkg::StIdle: begin
        ctrl_o.load_wr   = start && op_i == mgi_pkg::OpLoad;
        ctrl_o.capture   = start && op_i == mgi_pkg::OpEval;
        ctrl_o.acc_clear = start && op_i == mgi_pkg::OpEval;
      end
      mgi_pkg::StMap:    ctrl_o.map_en = 1'b1;
      mgi_pkg::StCorner: begin
        ctrl_o.weight_en = step_q <= LastWStep;
        ctrl_o.corner_rd = step_q > LastWStep;
      end
      mgi_pkg::StDrain:  ;
      mgi_pkg::StEmit:   ctrl_o.emit = 1'b1;
      default: ;
    endcase
  end

  assign busy = state_q != mgi_pkg::StIdle;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= mgi_pkg::StIdle;
      step_q   <= '0;
      corner_q <= '0;
      dim_q    <= '0;
      drain_q  <= '0;
      field_q  <= '0;
      acc_v_q  <= 1'b0;
      acc_f_q  <= '0;
    end else begin
      state_q  <= state_d;
      step_q   <= step_d;
      corner_q <= corner_d;
      dim_q    <= dim_d;
      drain_q  <= drain_d;
      field_q  <= field_d;
      // acc_en is raised while the read data sits in rd_q, ahead of the product register.
      acc_v_q  <= state_q == mgi_pkg::StCorner && step_q > LastWStep;
      acc_f_q  <= mgi_pkg::FieldW'(step_q - StepW'(mgi_pkg::Dims));
    end
  end

endmodule

`default_nettype wire

[rtl/mgi_dpath.sv]
// ----------------------------------------------------------------------------
// mgi_dpath
// Coordinate mapping, corner weights, table memory and field accumulators.
// ----------------------------------------------------------------------------
`default_nettype none

module mgi_dpath (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  mgi_pkg::ctrl_t     ctrl_i,
  input  wire logic [mgi_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [31:0]   cfg_data_i,
  input  wire logic          cfg_we_i,
  input  wire logic signed [31:0] coord_0_i,
  input  wire logic signed [31:0] coord_1_i,
  input  wire logic signed [31:0] coord_2_i,
  input  wire logic signed [31:0] coord_3_i,
  input  wire logic [11:0]   entry_index_i,
  input  wire logic [1:0]    load_field_i,
  input  wire logic signed [31:0] load_value_i,
  output logic               done_o,
  output logic [1:0]         field_number_o,
  output logic signed [31:0] interp_value_o,
  output logic               last_field_o,
  output logic               out_of_grid_o
);

  localparam int unsigned D = mgi_pkg::Dims;
  localparam logic [32:0] Limit = 33'(mgi_pkg::PointsPerDim - 1) << 16;

  logic [31:0] min_q [4];
  logic [31:0] inv_q [4];
  logic signed [31:0] coord_q [4];
  logic [mgi_pkg::CellW-1:0] cell_q [D];
  logic [16:0] frac_q [D];
  logic flag_q;
  logic [16:0] w_q;
  logic [mgi_pkg::PointW-1:0] flat_q;
  logic [31:0] mem [mgi_pkg::TableDepth];
  logic [31:0] rd_q;
  logic signed [mgi_pkg::AccW-1:0] acc_q [mgi_pkg::NumFields];

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        min_q[i] <= '0;
        inv_q[i] <= 32'd65536;
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i[2]) inv_q[cfg_idx_i[1:0]] <= cfg_data_i;
      else              min_q[cfg_idx_i[1:0]] <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      coord_q[0] <= coord_0_i;
      coord_q[1] <= coord_1_i;
      coord_q[2] <= coord_2_i;
      coord_q[3] <= coord_3_i;
    end
  end

  // One dimension per cycle: offset, one 33x32 multiply, clamp.
  logic signed [32:0] t;
  logic [32:0] tmag;
  logic [64:0] mag;
  logic [48:0] pos;
  logic [32:0] p;
  logic clamp;
  logic [1:0] md;
  always_comb begin
    md   = 2'(ctrl_i.map_dim);
    t    = 33'(coord_q[md]) - 33'(signed'(min_q[md]));
    tmag = t[32] ? 33'(-t) : t;
    mag  = 65'(tmag) * 65'(inv_q[md]);
    pos  = mag[64:16];
    clamp = 1'b0;
    if (t[32] && mag != '0) begin
      p = '0; clamp = 1'b1;
    end else if (pos > 49'(Limit)) begin
      p = Limit; clamp = 1'b1;
    end else begin
      p = pos[32:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q <= 1'b0;
    end else if (ctrl_i.capture) begin
      flag_q <= 1'b0;
    end else if (ctrl_i.map_en) begin
      flag_q <= flag_q | clamp;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.map_en) begin
      if (p[32:16] >= 17'(mgi_pkg::PointsPerDim - 1)) begin
        cell_q[ctrl_i.map_dim] <= mgi_pkg::CellW'(mgi_pkg::PointsPerDim - 2);
        frac_q[ctrl_i.map_dim] <= 17'd65536;
      end else begin
        cell_q[ctrl_i.map_dim] <= p[16+mgi_pkg::CellW-1:16];
        frac_q[ctrl_i.map_dim] <= {1'b0, p[15:0]};
      end
    end
  end

  // Weight and flat index, one dimension per cycle.
  logic bit_d;
  logic [16:0] fac;
  logic [33:0] wprod;
  logic [mgi_pkg::PointW-1:0] flat_d;
  logic [mgi_pkg::PointW-1:0] flat_base;
  always_comb begin
    bit_d = ctrl_i.corner[D - 1 - int'(ctrl_i.weight_dim)];
    fac   = bit_d ? frac_q[ctrl_i.weight_dim] : 17'd65536 - frac_q[ctrl_i.weight_dim];
    flat_base = (ctrl_i.weight_dim == '0) ? '0 : flat_q;
    wprod = 34'(((ctrl_i.weight_dim == '0) ? 17'd65536 : w_q)) * 34'(fac) + 34'd32768;
    flat_d = mgi_pkg::PointW'(flat_base * mgi_pkg::PointW'(mgi_pkg::PointsPerDim))
           + mgi_pkg::PointW'(cell_q[ctrl_i.weight_dim]) + mgi_pkg::PointW'(bit_d);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.weight_en) begin
      w_q    <= wprod[32:16];
      flat_q <= flat_d;
    end
  end

  // Table memory.
  logic [mgi_pkg::AddrW-1:0] rd_addr;
  logic [mgi_pkg::FieldW-1:0] rd_field;
  logic [mgi_pkg::FieldW-1:0] rd_field_q;
  assign rd_field = rd_field_q;
  assign rd_addr  = {flat_q, rd_field};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_field_q <= '0;
    end else if (ctrl_i.weight_en) begin
      rd_field_q <= '0;
    end else if (ctrl_i.corner_rd) begin
      rd_field_q <= rd_field_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_wr) begin
      mem[{entry_index_i, load_field_i}] <= load_value_i;
    end
    if (ctrl_i.corner_rd) begin
      rd_q <= mem[rd_addr];
    end
  end

  // Product registered before accumulation.
  logic signed [49:0] prod_q;
  logic prod_v_q;
  logic [mgi_pkg::FieldW-1:0] prod_f_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_v_q <= 1'b0;
    end else begin
      prod_v_q <= ctrl_i.acc_en;
    end
  end
  always_ff @(posedge clk_i) begin
    prod_q   <= signed'({1'b0, w_q}) * signed'(rd_q);
    prod_f_q <= ctrl_i.emit_field;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.acc_clear) begin
      for (int k = 0; k < mgi_pkg::NumFields; k++) acc_q[k] <= '0;
    end else if (prod_v_q) begin
      acc_q[prod_f_q] <= acc_q[prod_f_q] + mgi_pkg::AccW'(prod_q);
    end
  end

  // Round, floor-shift and saturate.
  logic signed [mgi_pkg::AccW-1:0] rsum;
  logic signed [mgi_pkg::AccW-17:0] rq;
  always_comb begin
    rsum = acc_q[ctrl_i.emit_field] + mgi_pkg::AccW'(32768);
    rq   = rsum[mgi_pkg::AccW-1:16];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= ctrl_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.emit) begin
      field_number_o <= ctrl_i.emit_field;
      last_field_o   <= ctrl_i.emit_field == mgi_pkg::FieldW'(mgi_pkg::NumFields - 1);
      out_of_grid_o  <= flag_q;
      if (rq > 40'sh007FFFFFFF)       interp_value_o <= 32'h7FFFFFFF;
      else if (rq < -40'sh0080000000) interp_value_o <= 32'h80000000;
      else                            interp_value_o <= rq[31:0];
    end
  end

endmodule

`default_nettype wire

[rtl/multilinear_grid_interpolator_top.sv]
// ----------------------------------------------------------------------------
// multilinear_grid_interpolator_top
// Multilinear interpolation of four fields on a uniform 4-D grid.
// ----------------------------------------------------------------------------
// A load beat (op 0) writes one table word. An evaluate beat (op 1) keeps
// busy high while it maps the coordinates, then walks each of the 16
// corners (4 weight steps on one multiplier, 4 reads of the table's single
// read port), then drains and emits one result beat per field. Each result
// beat appears in the cycle after its emit cycle, so the last one is out
// in the first idle cycle, and the next beat can be taken at the end of
// that cycle. Each result beat is on the outputs for one cycle under
// result_valid_o and cannot be stalled.
// The table powers up undefined; only written entries may be read.
`default_nettype none

module multilinear_grid_interpolator_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        op_i,
  input  wire logic signed [31:0] coord_0_i,
  input  wire logic signed [31:0] coord_1_i,
  input  wire logic signed [31:0] coord_2_i,
  input  wire logic signed [31:0] coord_3_i,
  input  wire logic [11:0] entry_index_i,
  input  wire logic [1:0]  load_field_i,
  input  wire logic signed [31:0] load_value_i,
  output logic             result_valid_o,
  output logic [1:0]       field_number_o,
  output logic signed [31:0] interp_value_o,
  output logic             last_field_o,
  output logic             out_of_grid_o
);

  mgi_pkg::ctrl_t ctrl;

  mgi_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .op_i   (op_i),
    .busy   (busy),
    .ctrl_o (ctrl)
  );

  mgi_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .cfg_we_i       (cfg_we_i),
    .coord_0_i      (coord_0_i),
    .coord_1_i      (coord_1_i),
    .coord_2_i      (coord_2_i),
    .coord_3_i      (coord_3_i),
    .entry_index_i  (entry_index_i),
    .load_field_i   (load_field_i),
    .load_value_i   (load_value_i),
    .done_o         (result_valid_o),
    .field_number_o (field_number_o),
    .interp_value_o (interp_value_o),
    .last_field_o   (last_field_o),
    .out_of_grid_o  (out_of_grid_o)
  );

endmodule

`default_nettype wire
